/* rtl/core/upd_pkg.sv */
// Package: shared types, character constants and decode helpers for the URL percent decoder.
`timescale 1ns / 1ps
`default_nettype none
package upd_pkg;

  localparam logic [7:0] CHAR_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // escape progress
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2
  } phase_e;

  // one result beat as it travels from the front to the back
  typedef struct packed {
    logic [7:0] data;
    logic       data_vld;
    logic       eos;
  } upd_item_t;

  // uppercase hex digit -> {ok, nibble}
  function automatic logic [4:0] hex_upper(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // reserved / unsafe characters that an escape may produce
  function automatic logic is_listed(input logic [7:0] v);
    logic r;
    unique case (v) inside
      8'h20, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h28, 8'h29,
      8'h2B, 8'h2C, 8'h2F, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E,
      8'h3F, 8'h40, 8'h5B, 8'h5C, 8'h5D, 8'h5E, 8'h60, 8'h7B,
      8'h7C, 8'h7D, 8'h7E: r = 1'b1;
      default:             r = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/upd_front.sv */
// Front end: accepts input beats, tracks the escape phase and classifies each byte.
`timescale 1ns / 1ps
`default_nettype none
module upd_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         in_byte_i,
  input  wire logic               in_last_i,
  input  wire logic               q_full_i,
  output logic                    push_o,
  output upd_pkg::upd_item_t      push_item_o
);
  import upd_pkg::*;

  phase_e     phase_q, phase_d;
  logic [7:0] first_q;
  logic       accept;
  logic [4:0] hi_dig, lo_dig;
  logic [7:0] pair_val;
  upd_item_t  item;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // next state
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      unique case (phase_q)
        PH_FIRST:  phase_d = PH_SECOND;
        PH_SECOND: phase_d = PH_IDLE;
        default:   phase_d = (in_byte_i == CHAR_PCT) ? PH_FIRST : PH_IDLE;
      endcase
      if (in_last_i) phase_d = PH_IDLE;
    end
  end

  assign hi_dig   = hex_upper(first_q);
  assign lo_dig   = hex_upper(in_byte_i);
  assign pair_val = {hi_dig[3:0], lo_dig[3:0]};

  // outputs
  always_comb begin
    item.data     = 8'd0;
    item.data_vld = 1'b0;
    item.eos      = in_last_i;
    unique case (phase_q)
      PH_FIRST: begin
      end
      PH_SECOND: begin
        if (hi_dig[4] && lo_dig[4] && is_listed(pair_val)) begin
          item.data     = pair_val;
          item.data_vld = 1'b1;
        end
      end
      default: begin
        if (in_byte_i == CHAR_PLUS) begin
          item.data     = CHAR_SPACE;
          item.data_vld = 1'b1;
        end else if (in_byte_i != CHAR_PCT) begin
          item.data     = in_byte_i;
          item.data_vld = 1'b1;
        end
      end
    endcase
  end

  assign push_o      = accept && (item.data_vld || item.eos);
  assign push_item_o = item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && phase_q == PH_FIRST) begin
      first_q <= in_byte_i;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/upd_fifo.sv */
// Short result queue between the front end and the output stage.
`timescale 1ns / 1ps
`default_nettype none
module upd_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire upd_pkg::upd_item_t  push_item_i,
  input  wire logic                pop_i,
  output upd_pkg::upd_item_t       pop_item_o,
  output logic                     full_o,
  output logic                     empty_o
);
  import upd_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  upd_item_t         mem_q [DEPTH];
  logic [PW-1:0]     wr_q, rd_q;
  logic [CW-1:0]     cnt_q;
  logic              do_push, do_pop;

  assign full_o     = (cnt_q == CW'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_item_o = mem_q[rd_q];

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wrap_inc(wr_q);
      if (do_pop)  rd_q <= wrap_inc(rd_q);
      if (do_push && !do_pop)      cnt_q <= CW'(cnt_q + 1'b1);
      else if (do_pop && !do_push) cnt_q <= CW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_item_i;
  end

endmodule
`default_nettype wire

/* rtl/core/upd_back.sv */
// Back end: output register that drains the queue and holds a beat while stalled.
`timescale 1ns / 1ps
`default_nettype none
module upd_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_empty_i,
  input  wire upd_pkg::upd_item_t q_item_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [7:0]              out_byte_o,
  output logic                    byte_valid_o,
  output logic                    end_of_string_o
);
  import upd_pkg::*;

  logic      vld_q;
  upd_item_t out_q;

  // reload when the register is free or its beat leaves this cycle
  assign pop_o = !q_empty_i && (!vld_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (pop_o) begin
      vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) out_q <= q_item_i;
  end

  assign out_valid_o     = vld_q;
  assign out_byte_o      = out_q.data;
  assign byte_valid_o    = out_q.data_vld;
  assign end_of_string_o = out_q.eos;

endmodule
`default_nettype wire

/* rtl/core/url_percent_decoder.sv */
// Top level of the URL percent decoder: front end, result queue and output stage.
//
// Input channel: one encoded byte per beat (in_byte_i, in_last_i on the final
// byte of a string), handshake in_valid_i / in_stall_o.
// Output channel: at most one beat per input beat (out_byte_o, byte_valid_o,
// end_of_string_o), handshake out_valid_o / out_stall_i. A beat with
// byte_valid_o low only appears to carry end_of_string_o; out_byte_o is then 0.
// A '%' and its two digit bytes yield one beat or none; bytes that decode to
// nothing produce no output beat.
// Throughput: one input beat per cycle, sustained, while the output is not
// stalled. An accepted input beat is written into the queue and then loaded
// into the output register.
// The front end stalls only when the QUEUE_DEPTH-entry queue is full, so a
// stalled receiver backs up into the queue first and then into in_stall_o.
// Reset (rst_ni low, asynchronous) clears the escape phase, empties the queue
// and drops the output beat; no clearing pass is needed afterward.
`timescale 1ns / 1ps
`default_nettype none
module url_percent_decoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            byte_valid_o,
  output logic            end_of_string_o
);
  import upd_pkg::*;

  logic      push, pop, q_full, q_empty;
  upd_item_t push_item, pop_item;

  // classify bytes, track escape phase
  upd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_item_o (push_item)
  );

  // decouples front and back stalls
  upd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  // registered output beat
  upd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_item_i        (pop_item),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .byte_valid_o    (byte_valid_o),
    .end_of_string_o (end_of_string_o)
  );

endmodule
`default_nettype wire

/* rtl/core/upd_checker.sv */
// Port-level checker for the URL percent decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module upd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       byte_valid_o,
  input wire logic       end_of_string_o
);

  // stalled beat stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  // stalled beat keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(out_byte_o) && $stable(byte_valid_o) && $stable(end_of_string_o))
    else $error("output payload changed while stalled");

  // a beat without a byte exists only to mark end of string
  a_empty_eos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> end_of_string_o)
    else $error("empty output beat without end mark");

  // no byte means zero data
  a_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> out_byte_o == 8'd0)
    else $error("out_byte_o nonzero on empty beat");

endmodule

bind url_percent_decoder upd_checker u_upd_checker (.*);
`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for url_percent_decoder: random-gap driver, stalling receiver, checker.
`timescale 1ns / 1ps

module testbench;
  import upd_pkg::*;

  // Characters an escape is allowed to produce, packed one byte per slot.
  localparam int unsigned N_RESERVED = 27;
  localparam logic [N_RESERVED*8-1:0] RESERVED = {
    8'h24, 8'h26, 8'h2B, 8'h2C, 8'h2F, 8'h3A, 8'h3B, 8'h3D, 8'h3F, 8'h40,
    8'h20, 8'h22, 8'h3C, 8'h3E, 8'h23, 8'h25, 8'h7B, 8'h7D, 8'h7C, 8'h5C,
    8'h5E, 8'h7E, 8'h5B, 8'h5D, 8'h60, 8'h28, 8'h29
  };
  localparam int unsigned MAX_PRINTED = 20;

  // One raw byte waiting for the driver, with the idle cycles placed before it.
  typedef struct {
    logic [7:0]  raw;
    logic        last_flag;
    int unsigned hold;
  } raw_beat_t;

  logic       clk_i;
  logic       rst_ni          = 1'b0;
  logic       in_valid_i      = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i       = 8'h00;
  logic       in_last_i       = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i     = 1'b0;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic       end_of_string_o;

  raw_beat_t   pending_bytes[$];   // stimulus not yet driven
  logic [7:0]  strbuf[$];          // string under construction
  upd_item_t   expected_beats[$];  // decoded beats the block still owes us

  // Decoder shadow state, advanced on every accepted input beat.
  phase_e      esc_phase = PH_IDLE;
  logic [7:0]  esc_hi    = 8'h00;

  // Handshake observations from the rising edge, consumed at the falling edge.
  logic        in_took  = 1'b0;
  logic        out_took = 1'b0;

  int unsigned gap_cnt   = 0;
  int unsigned stall_cnt = 0;
  int unsigned rx_cycle  = 0;

  int unsigned err_count       = 0;
  int unsigned strings_queued  = 0;
  int unsigned bytes_in        = 0;
  int unsigned beats_checked   = 0;
  int unsigned decoded_bytes   = 0;
  int unsigned dropped_escapes = 0;

  url_percent_decoder DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .in_last_i      (in_last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .byte_valid_o   (byte_valid_o),
    .end_of_string_o(end_of_string_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Reset once, released away from the rising edge.
  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Hard stop. The slowest legal run, roughly 1.2k bytes each with its longest
  // idle gap, receiver stall and pipeline delay, ends well under 5 ms.
  initial begin
    #5_000_000;
    $display("Timeout: %0d beats still expected", expected_beats.size());
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic log_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTED) $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // Uppercase hex digit value, or -1 for anything else (lowercase included).
  function automatic int hex_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h37 + 8'(n);
  endfunction

  function automatic bit is_reserved(input logic [7:0] v);
    for (int k = 0; k < N_RESERVED; k++) begin
      if (RESERVED[k*8 +: 8] == v) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Shadow of the decoder: one raw byte in, zero or one expected beat out.
  task automatic decode_beat(input logic [7:0] raw, input logic last_flag);
    upd_item_t r;
    bit        got;
    int        hv;
    int        lv;
    logic [7:0] v;
    r   = '0;
    got = 1'b0;
    case (esc_phase)
      PH_FIRST: begin
        esc_hi    = raw;
        esc_phase = PH_SECOND;
      end
      PH_SECOND: begin
        // both digits are swallowed; only a listed uppercase pair yields a byte
        hv = hex_value(esc_hi);
        lv = hex_value(raw);
        if (hv >= 0 && lv >= 0) begin
          v = {4'(hv), 4'(lv)};
          if (is_reserved(v)) begin
            r.data = v;
            got    = 1'b1;
          end
        end
        esc_phase = PH_IDLE;
      end
      default: begin
        // idle, and the unreachable fourth phase behaves the same
        esc_phase = PH_IDLE;
        if (raw == CHAR_PCT) begin
          esc_phase = PH_FIRST;
        end else begin
          r.data = (raw == CHAR_PLUS) ? CHAR_SPACE : raw;
          got    = 1'b1;
        end
      end
    endcase
    // an escape still open at the end of the string is thrown away
    if (last_flag) begin
      if (esc_phase != PH_IDLE) dropped_escapes++;
      esc_phase = PH_IDLE;
    end
    if (got || last_flag) begin
      r.data_vld = got;
      r.eos      = last_flag;
      expected_beats.push_back(r);
    end
  endtask

  // Moves the string under construction into the driver queue; the final
  // byte carries the end mark. A calm string is sent back to back.
  task automatic flush_string(input bit calm);
    raw_beat_t rb;
    for (int k = 0; k < strbuf.size(); k++) begin
      rb.raw       = strbuf[k];
      rb.last_flag = (k == strbuf.size() - 1);
      rb.hold      = calm ? 0 : $urandom_range(0, 6);
      pending_bytes.push_back(rb);
    end
    strbuf.delete();
    strings_queued++;
  endtask

  // Rising edge: record handshakes, predict on input beats, check output beats.
  always @(posedge clk_i) begin : monitor
    upd_item_t exp_beat;
    in_took  <= rst_ni && in_valid_i && !in_stall_o;
    out_took <= rst_ni && out_valid_o && !out_stall_i;
    // predict first, so a same-edge result would still find its expectation
    if (rst_ni && in_valid_i && !in_stall_o) begin
      bytes_in++;
      decode_beat(in_byte_i, in_last_i);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beats_checked++;
      if (expected_beats.size() == 0) begin
        log_mismatch($sformatf("unexpected beat byte=%02h vld=%0b eos=%0b",
                               out_byte_o, byte_valid_o, end_of_string_o));
      end else begin
        exp_beat = expected_beats.pop_front();
        if (byte_valid_o === 1'b1) decoded_bytes++;
        if (byte_valid_o !== exp_beat.data_vld)
          log_mismatch($sformatf("byte_valid %b, expected %b", byte_valid_o,
                                 exp_beat.data_vld));
        if (out_byte_o !== exp_beat.data)
          log_mismatch($sformatf("out_byte %02h, expected %02h", out_byte_o,
                                 exp_beat.data));
        if (end_of_string_o !== exp_beat.eos)
          log_mismatch($sformatf("end_of_string %b, expected %b", end_of_string_o,
                                 exp_beat.eos));
      end
    end
  end

  // Falling edge: sender. A beat is held until taken; the next one follows
  // after its own idle count, in the same step when that count is zero.
  always @(negedge clk_i) begin : driver
    logic       nv;
    logic [7:0] nb;
    logic       nl;
    raw_beat_t  rb;
    nv = in_valid_i;
    nb = in_byte_i;
    nl = in_last_i;
    if (nv && in_took) nv = 1'b0;
    if (!nv && rst_ni && pending_bytes.size() != 0) begin
      if (gap_cnt < pending_bytes[0].hold) begin
        gap_cnt++;
      end else begin
        rb      = pending_bytes.pop_front();
        nv      = 1'b1;
        nb      = rb.raw;
        nl      = rb.last_flag;
        gap_cnt = 0;
      end
    end
    in_valid_i <= nv;
    in_byte_i  <= nb;
    in_last_i  <= nl;
  end

  // Falling edge: receiver. After each taken beat it draws a random stall;
  // in a recurring window of rx_cycle it draws no stall at all.
  always @(negedge clk_i) begin : receiver
    rx_cycle++;
    if (out_took) stall_cnt = ((rx_cycle % 400) < 120) ? 0 : $urandom_range(0, 6);
    out_stall_i <= (stall_cnt != 0);
    if (stall_cnt != 0) stall_cnt--;
  end

  initial begin : stimulus
    int unsigned counted;
    int unsigned len;
    int unsigned kind;
    logic [7:0]  v;

    // Directed: byte extremes, plus to space, listed escapes, lowercase and
    // non-hex digits, a valid pair that is not listed, escape on the last byte.
    strbuf.push_back(8'h00);
    strbuf.push_back(8'hFF);
    strbuf.push_back(CHAR_PLUS);
    strbuf.push_back(CHAR_PCT); strbuf.push_back("2"); strbuf.push_back("B");
    strbuf.push_back(CHAR_PCT); strbuf.push_back("7"); strbuf.push_back("E");
    strbuf.push_back("a");
    flush_string(1'b1);
    strbuf.push_back(CHAR_PCT); strbuf.push_back("3"); strbuf.push_back("a");
    strbuf.push_back(CHAR_PCT); strbuf.push_back("4"); strbuf.push_back("1");
    strbuf.push_back(CHAR_PCT); strbuf.push_back("G"); strbuf.push_back("0");
    strbuf.push_back(CHAR_PCT); strbuf.push_back("2"); strbuf.push_back("9");
    flush_string(1'b0);
    // escapes cut short by the end of the string, at either digit
    strbuf.push_back(CHAR_PCT);
    flush_string(1'b0);
    strbuf.push_back(CHAR_PCT); strbuf.push_back("2");
    flush_string(1'b0);

    // Random strings: mostly plain text and well-formed escapes, the rest
    // broken escapes and raw noise. Strings are added until about 1150 raw
    // bytes are queued.
    counted = 0;
    while (counted < 1150) begin
      len = $urandom_range(1, 14);
      for (int i = 0; i < len; i++) begin
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
          v = 8'($urandom_range(0, 255));
          if (v == CHAR_PCT) v = CHAR_PLUS;
          strbuf.push_back(v);
        end else if (kind < 42) begin
          strbuf.push_back(CHAR_PLUS);
        end else if (kind < 75) begin
          v = RESERVED[$urandom_range(0, N_RESERVED - 1)*8 +: 8];
          strbuf.push_back(CHAR_PCT);
          strbuf.push_back(hex_char(v[7:4]));
          strbuf.push_back(hex_char(v[3:0]));
        end else if (kind < 84) begin
          // well-formed pair of any value, mostly not listed
          v = 8'($urandom_range(0, 255));
          strbuf.push_back(CHAR_PCT);
          strbuf.push_back(hex_char(v[7:4]));
          strbuf.push_back(hex_char(v[3:0]));
        end else if (kind < 92) begin
          // arbitrary digit bytes: lowercase, non-hex, even another percent
          strbuf.push_back(CHAR_PCT);
          strbuf.push_back(8'($urandom_range(0, 255)));
          strbuf.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 96) begin
          // dangling escape; later bytes become its digits
          strbuf.push_back(CHAR_PCT);
          if ($urandom_range(0, 1) == 1) strbuf.push_back(hex_char(4'($urandom_range(0, 15))));
        end else begin
          strbuf.push_back(8'($urandom_range(0, 255)));
        end
      end
      counted += strbuf.size();
      flush_string($urandom_range(0, 3) == 0);
    end

    // Drain: all bytes taken and every expected beat seen, then a few more
    // cycles to catch any stray beat.
    @(posedge rst_ni);
    while (pending_bytes.size() != 0 || in_valid_i || expected_beats.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (expected_beats.size() != 0)
      log_mismatch($sformatf("%0d beats never arrived", expected_beats.size()));

    $display("Sent %0d strings (%0d raw bytes); %0d escapes were cut by end of string.",
             strings_queued, bytes_in, dropped_escapes);
    $display("Checked %0d output beats, %0d carrying a byte; %0d mismatches.",
             beats_checked, decoded_bytes, err_count);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
